// ===== src/atd_pkg.sv =====
// ----------------------------------------------------------------------------
// atd_pkg
// Shared types and constants of the activation table with decay.
// ----------------------------------------------------------------------------
package atd_pkg;

    // input command codes
    localparam logic CMD_ACTIVATE = 1'b0;
    localparam logic CMD_DECAY    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_INSERT  = 2'd1;
    localparam logic [1:0] ST_EVICT   = 2'd2;
    localparam logic [1:0] ST_DECAYED = 2'd3;

    // configuration register map (word index = paddr[2])
    localparam int         APB_ADDR_W = 3;
    localparam logic       REG_DECAY  = 1'b0;
    localparam logic       REG_THRESH = 1'b1;

    localparam logic [15:0] DECAY_RESET  = 16'd58982;
    localparam logic [15:0] THRESH_RESET = 16'd3277;
    localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [15:0] decay_factor;
        logic [15:0] drop_threshold;
    } cfg_t;

endpackage

// ===== src/activation_table_with_decay_top.sv =====
// ----------------------------------------------------------------------------
// activation_table_with_decay_top
// Activate scans the live entries until a hit or the last one; a miss on a full
// table adds an evict and an insert step. A decay tick scans every live entry and
// adds a move step per removed entry that was not the last live one when it dropped.
// One word at a time: the scan reads one entry per cycle on one read port, bar moves.
// Reset clears the entry count, state and out_valid; key and level memories are not.
// ----------------------------------------------------------------------------
module activation_table_with_decay_top
    import atd_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [63:0]           node_key,
    input  logic [15:0]           boost,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [63:0]           evicted_key,
    output logic [15:0]           level_now,
    output logic [7:0]            removed_count,
    output logic [7:0]            entry_count,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ASCAN  = 3'd1;
    localparam logic [2:0] S_AEVICT = 3'd2;
    localparam logic [2:0] S_AINS   = 3'd3;
    localparam logic [2:0] S_DSCAN  = 3'd4;
    localparam logic [2:0] S_DMOVE  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    cfg_t cfg;

    atd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // entry memories
    logic [63:0] key_mem [CAPACITY];
    logic [15:0] lvl_mem [CAPACITY];
    logic [63:0] key_rd_reg;
    logic [15:0] lvl_rd_reg;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          key_we;
    logic          lvl_we;
    logic [63:0]   wr_key;
    logic [15:0]   wr_lvl;

    // control and working registers
    logic [2:0]    state_reg,   state_next;
    logic [CW-1:0] live_reg,    live_next;
    logic [CW-1:0] p_idx_reg,   p_idx_next;
    logic          p_moved_reg, p_moved_next;
    logic [63:0]   key_reg,     key_next;
    logic [15:0]   boost_reg,   boost_next;
    logic [15:0]   min_lvl_reg, min_lvl_next;
    logic [CW-1:0] min_idx_reg, min_idx_next;
    logic [63:0]   min_key_reg, min_key_next;
    logic [63:0]   last_key_reg, last_key_next;
    logic [15:0]   last_lvl_reg, last_lvl_next;
    logic [CW-1:0] rm_reg,      rm_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [63:0]   res_evict_reg,  res_evict_next;
    logic [15:0]   res_level_reg,  res_level_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_load;
    logic [1:0]    out_status_reg;
    logic [63:0]   out_evict_reg;
    logic [15:0]   out_level_reg;
    logic [7:0]    out_rm_reg;
    logic [7:0]    out_count_reg;

    // datapath
    logic [CW-1:0] idx_plus;
    logic [CW-1:0] live_m1;
    logic [16:0]   sum17;
    logic [15:0]   sat_lvl;
    logic [31:0]   prod;
    logic [15:0]   dec_lvl;
    logic          drop;
    logic          take_min;

    assign idx_plus = p_idx_reg + CW'(1);
    assign live_m1  = live_reg - CW'(1);
    assign sum17    = {1'b0, lvl_rd_reg} + {1'b0, boost_reg};
    assign sat_lvl  = sum17[16] ? LEVEL_MAX : sum17[15:0];
    assign prod     = 32'(lvl_rd_reg) * 32'(cfg.decay_factor);
    assign dec_lvl  = prod[31:16];
    assign drop     = dec_lvl < cfg.drop_threshold;
    assign take_min = (p_idx_reg == '0) || (lvl_rd_reg < min_lvl_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[rd_addr];
        lvl_rd_reg <= lvl_mem[rd_addr];
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (lvl_we)
        begin
            lvl_mem[wr_addr] <= wr_lvl;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        p_idx_next      = p_idx_reg;
        p_moved_next    = p_moved_reg;
        key_next        = key_reg;
        boost_next      = boost_reg;
        min_lvl_next    = min_lvl_reg;
        min_idx_next    = min_idx_reg;
        min_key_next    = min_key_reg;
        last_key_next   = last_key_reg;
        last_lvl_next   = last_lvl_reg;
        rm_next         = rm_reg;
        res_status_next = res_status_reg;
        res_evict_next  = res_evict_reg;
        res_level_next  = res_level_reg;
        rd_addr         = idx_plus[IW-1:0];
        wr_addr         = p_idx_reg[IW-1:0];
        key_we          = 1'b0;
        lvl_we          = 1'b0;
        wr_key          = key_reg;
        wr_lvl          = boost_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = node_key;
                    boost_next   = boost;
                    rm_next      = '0;
                    p_idx_next   = '0;
                    p_moved_next = 1'b0;
                    rd_addr      = '0;
                    if (cmd == CMD_DECAY)
                    begin
                        if (live_reg == '0)
                        begin
                            res_status_next = ST_DECAYED;
                            res_evict_next  = 64'd0;
                            res_level_next  = 16'd0;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_DSCAN;
                        end
                    end
                    else if (live_reg == '0)
                    begin
                        wr_addr         = '0;
                        wr_key          = node_key;
                        wr_lvl          = boost;
                        key_we          = 1'b1;
                        lvl_we          = 1'b1;
                        live_next       = CW'(1);
                        res_status_next = ST_INSERT;
                        res_evict_next  = 64'd0;
                        res_level_next  = boost;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end

            S_ASCAN:
            begin
                if (key_rd_reg == key_reg)
                begin
                    wr_lvl          = sat_lvl;
                    lvl_we          = 1'b1;
                    res_status_next = ST_HIT;
                    res_evict_next  = 64'd0;
                    res_level_next  = sat_lvl;
                    state_next      = S_FIN;
                end
                else
                begin
                    if (take_min)
                    begin
                        min_lvl_next = lvl_rd_reg;
                        min_idx_next = p_idx_reg;
                        min_key_next = key_rd_reg;
                    end
                    last_key_next = key_rd_reg;
                    last_lvl_next = lvl_rd_reg;
                    if (p_idx_reg == live_m1)
                    begin
                        if (live_reg == CAP_C)
                        begin
                            state_next = S_AEVICT;
                        end
                        else
                        begin
                            wr_addr         = live_reg[IW-1:0];
                            key_we          = 1'b1;
                            lvl_we          = 1'b1;
                            live_next       = idx_plus + CW'(1);
                            res_status_next = ST_INSERT;
                            res_evict_next  = 64'd0;
                            res_level_next  = boost_reg;
                            state_next      = S_FIN;
                        end
                    end
                    else
                    begin
                        p_idx_next = idx_plus;
                    end
                end
            end

            // last entry fills the evicted slot
            S_AEVICT:
            begin
                wr_addr    = min_idx_reg[IW-1:0];
                wr_key     = last_key_reg;
                wr_lvl     = last_lvl_reg;
                key_we     = 1'b1;
                lvl_we     = 1'b1;
                state_next = S_AINS;
            end

            S_AINS:
            begin
                wr_addr         = LAST_IDX;
                key_we          = 1'b1;
                lvl_we          = 1'b1;
                res_status_next = ST_EVICT;
                res_evict_next  = min_key_reg;
                res_level_next  = boost_reg;
                state_next      = S_FIN;
            end

            S_DSCAN:
            begin
                if (!drop)
                begin
                    wr_lvl = dec_lvl;
                    wr_key = key_rd_reg;
                    lvl_we = 1'b1;
                    key_we = p_moved_reg;
                    if (idx_plus == live_reg)
                    begin
                        res_status_next = ST_DECAYED;
                        res_evict_next  = 64'd0;
                        res_level_next  = 16'd0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        p_idx_next   = idx_plus;
                        p_moved_next = 1'b0;
                    end
                end
                else
                begin
                    rm_next   = rm_reg + CW'(1);
                    live_next = live_m1;
                    if (p_idx_reg == live_m1)
                    begin
                        res_status_next = ST_DECAYED;
                        res_evict_next  = 64'd0;
                        res_level_next  = 16'd0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // speculative read of idx+1 is dropped
                        state_next = S_DMOVE;
                    end
                end
            end

            // fetch old last entry; it is decayed in the dropped slot next
            S_DMOVE:
            begin
                rd_addr      = live_reg[IW-1:0];
                p_moved_next = 1'b1;
                state_next   = S_DSCAN;
            end

            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg      <= p_idx_next;
        p_moved_reg    <= p_moved_next;
        key_reg        <= key_next;
        boost_reg      <= boost_next;
        min_lvl_reg    <= min_lvl_next;
        min_idx_reg    <= min_idx_next;
        min_key_reg    <= min_key_next;
        last_key_reg   <= last_key_next;
        last_lvl_reg   <= last_lvl_next;
        rm_reg         <= rm_next;
        res_status_reg <= res_status_next;
        res_evict_reg  <= res_evict_next;
        res_level_reg  <= res_level_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_evict_reg  <= res_evict_reg;
            out_level_reg  <= res_level_reg;
            out_rm_reg     <= 8'(rm_reg);
            out_count_reg  <= 8'(live_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign evicted_key   = out_evict_reg;
    assign level_now     = out_level_reg;
    assign removed_count = out_rm_reg;
    assign entry_count   = out_count_reg;

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CAP_C)
        else $error("entry count above capacity");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ASCAN || state_reg == S_DSCAN) |-> p_idx_reg < live_reg)
        else $error("scan index beyond live entries");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AEVICT) |-> (live_reg == CAP_C && min_idx_reg < live_reg))
        else $error("eviction without a full table");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_status_reg)
            && $stable(out_count_reg)))
        else $error("stalled result word changed");
`endif

endmodule

// ===== src/atd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// atd_cfg_regs
// APB-style configuration registers: decay factor and drop threshold.
// ----------------------------------------------------------------------------
module atd_cfg_regs
    import atd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] decay_reg;
    logic [15:0] thresh_reg;
    logic        wr_en;

    // low address bits are ignored; word index is bit 2
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_DECAY:  decay_reg  <= pwdata[15:0];
                REG_THRESH: thresh_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DECAY:  prdata = {16'd0, decay_reg};
            REG_THRESH: prdata = {16'd0, thresh_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.decay_factor   = decay_reg;
    assign cfg.drop_threshold = thresh_reg;

endmodule

// ===== sim/tb_activation_table_with_decay_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_activation_table_with_decay_top
// Drives activate words and decay ticks into the activation table and checks
// every result word against a shadow copy of the table kept in the bench.
// Runs a directed opening, then random traffic under several decay/threshold
// settings (reset, extremes, harsh), with bursty input and patterned output
// stalls.
// ----------------------------------------------------------------------------
module tb_activation_table_with_decay_top
    import atd_pkg::*;
;

    localparam int CAPACITY       = 128;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POOL_SIZE      = 512;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] evicted_key;
        logic [15:0] level_now;
        logic [7:0]  removed_count;
        logic [7:0]  entry_count;
    } table_result_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [63:0]           node_key;
    logic [15:0]           boost;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [63:0]           evicted_key;
    logic [15:0]           level_now;
    logic [7:0]            removed_count;
    logic [7:0]            entry_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // shadow of the table contents and registers
    logic [63:0]   shadow_key [CAPACITY];
    logic [15:0]   shadow_level [CAPACITY];
    int unsigned   shadow_count = 0;
    logic [15:0]   decay_setting = DECAY_RESET;
    logic [15:0]   thresh_setting = THRESH_RESET;

    table_result_t pending_results [$];
    logic [63:0]   key_pool [POOL_SIZE];

    int burst_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int words_sent = 0;
    int hit_count = 0;
    int insert_count = 0;
    int evict_count = 0;
    int tick_count = 0;
    int dropped_total = 0;
    int settings_used = 0;

    activation_table_with_decay_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .node_key(node_key),
        .boost(boost),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .evicted_key(evicted_key),
        .level_now(level_now),
        .removed_count(removed_count),
        .entry_count(entry_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void drop_slot(input int unsigned slot);
        shadow_key[slot]   = shadow_key[shadow_count - 1];
        shadow_level[slot] = shadow_level[shadow_count - 1];
        shadow_count--;
    endfunction

    function automatic table_result_t table_update(input logic op, input logic [63:0] key,
                                                   input logic [15:0] amount);
        table_result_t r;
        int unsigned   idx;
        int unsigned   low_idx;
        logic [31:0]   sum;
        logic [31:0]   scaled;
        bit            found;
        r = '0;
        found = 1'b0;
        if (op == CMD_ACTIVATE)
        begin
            for (idx = 0; idx < shadow_count; idx++)
            begin
                if (!found && shadow_key[idx] == key)
                begin
                    sum = 32'(shadow_level[idx]) + 32'(amount);
                    if (sum > 32'(LEVEL_MAX))
                        sum = 32'(LEVEL_MAX);
                    shadow_level[idx] = sum[15:0];
                    r.level_now = sum[15:0];
                    r.status = ST_HIT;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = ST_INSERT;
                if (shadow_count >= CAPACITY)
                begin
                    low_idx = 0;
                    for (idx = 1; idx < shadow_count; idx++)
                        if (shadow_level[idx] < shadow_level[low_idx])
                            low_idx = idx;
                    r.evicted_key = shadow_key[low_idx];
                    drop_slot(low_idx);
                    r.status = ST_EVICT;
                end
                shadow_key[shadow_count] = key;
                shadow_level[shadow_count] = amount;
                shadow_count++;
                r.level_now = amount;
            end
        end
        else
        begin
            // a word swapped into a dropped slot is decayed there on the next pass
            idx = 0;
            while (idx < shadow_count)
            begin
                scaled = (32'(shadow_level[idx]) * 32'(decay_setting)) >> 16;
                shadow_level[idx] = scaled[15:0];
                if (scaled < 32'(thresh_setting))
                begin
                    drop_slot(idx);
                    r.removed_count++;
                end
                else
                    idx++;
            end
            r.status = ST_DECAYED;
        end
        r.entry_count = shadow_count[7:0];
        return r;
    endfunction

    // one input word, with burst/gap shaping on the sender side
    task automatic send_word(input logic op, input logic [63:0] key, input logic [15:0] amount);
        int gap;
        table_result_t want;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= op;
        node_key <= key;
        boost    <= amount;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = table_update(op, key, amount);
        pending_results.push_back(want);
        words_sent++;
        case (want.status)
            ST_HIT:    hit_count++;
            ST_INSERT: insert_count++;
            ST_EVICT:  evict_count++;
            default:
            begin
                tick_count++;
                dropped_total += want.removed_count;
            end
        endcase
    endtask

    task automatic send_decay();
        send_word(CMD_DECAY, {$urandom, $urandom}, 16'($urandom));
    endtask

    // sender holds off until every result is back
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic idx, input logic [15:0] val,
                            output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic idx, input logic [15:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, 16'h0000, rd);
        if (rd[15:0] !== want)
        begin
            $error("register %0d readback: expected %0d, got %0d", idx, want, rd[15:0]);
            error_count++;
        end
    endtask

    task automatic program_register(input logic idx, input logic [15:0] val);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        if (idx == REG_DECAY)
            decay_setting = val;
        else
            thresh_setting = val;
        settings_used++;
        check_register(idx, val);
    endtask

    task automatic run_traffic(input int count, input int pool_span, input int decay_pct,
                               input int zero_pct);
        int          n;
        logic [63:0] key;
        logic [15:0] amount;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(1, 100) <= decay_pct)
                send_decay();
            else
            begin
                key = (pool_span == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, pool_span - 1)];
                if ($urandom_range(1, 100) <= zero_pct)
                    amount = 16'h0000;
                else if ($urandom_range(0, 15) == 0)
                    amount = LEVEL_MAX;
                else if ($urandom_range(0, 7) == 0)
                    amount = 16'($urandom_range(1, 4000));
                else
                    amount = 16'($urandom);
                send_word(CMD_ACTIVATE, key, amount);
            end
        end
    endtask

    task automatic test_register_defaults();
        check_register(REG_DECAY, DECAY_RESET);
        check_register(REG_THRESH, THRESH_RESET);
    endtask

    task automatic test_directed_cases();
        send_decay();                                          // empty table
        send_word(CMD_ACTIVATE, 64'h0, 16'h0000);              // zero boost insert
        send_word(CMD_ACTIVATE, '1, LEVEL_MAX);
        send_word(CMD_ACTIVATE, '1, 16'h0001);                 // saturates
        send_word(CMD_ACTIVATE, 64'h0, 16'h7FFF);
        send_word(CMD_ACTIVATE, 64'h0, 16'h8001);              // sum exactly one over max
        send_word(CMD_ACTIVATE, 64'h5555_5555_5555_5555, 16'd3276);
        send_word(CMD_ACTIVATE, 64'hAAAA_AAAA_AAAA_AAAA, 16'd3641);
        send_word(CMD_ACTIVATE, 64'h8000_0000_0000_0001, 16'd1);
        // chain of drops: each moved-in word is itself low and drops in turn
        send_decay();
        send_decay();
        send_word(CMD_ACTIVATE, 64'h5555_5555_5555_5555, 16'h1234);
        send_word(CMD_ACTIVATE, 64'h0, LEVEL_MAX);
        send_decay();
        send_decay();
    endtask

    task automatic test_churn_small_table();
        run_traffic(330, 48, 12, 5);
    endtask

    // no drops at all, so the table fills and then every miss evicts
    task automatic test_fill_and_evict();
        wait_for_idle();
        program_register(REG_DECAY, 16'hFFFF);
        program_register(REG_THRESH, 16'h0000);
        run_traffic(420, POOL_SIZE, 3, 20);
    endtask

    task automatic test_full_wipe();
        int n;
        wait_for_idle();
        program_register(REG_DECAY, 16'h0000);
        program_register(REG_THRESH, 16'h0001);
        send_decay();                                          // drops the full table
        send_decay();
        wait_for_idle();
        program_register(REG_DECAY, 16'hFFFF);
        program_register(REG_THRESH, 16'hFFFF);
        for (n = 0; n < 10; n++)
            send_word(CMD_ACTIVATE, key_pool[n], LEVEL_MAX);
        send_decay();
    endtask

    task automatic test_harsh_decay();
        wait_for_idle();
        program_register(REG_DECAY, 16'h8000);
        program_register(REG_THRESH, 16'd20000);
        run_traffic(260, 64, 20, 5);
    endtask

    task automatic test_extreme_settings();
        wait_for_idle();
        program_register(REG_DECAY, 16'h0000);
        program_register(REG_THRESH, 16'h0000);
        run_traffic(120, 200, 10, 10);                         // levels collapse to zero
        wait_for_idle();
        program_register(REG_DECAY, 16'hFFFF);
        program_register(REG_THRESH, 16'hFFFF);
        run_traffic(100, 32, 10, 5);
    endtask

    task automatic test_fresh_keys();
        wait_for_idle();
        program_register(REG_DECAY, DECAY_RESET);
        program_register(REG_THRESH, THRESH_RESET);
        run_traffic(300, 0, 8, 3);
    endtask

    // receiver stall pattern
    initial
    begin
        stall_mode_t mode;
        int          left;
        int          phase;
        out_stall <= 1'b0;
        mode = STALL_NONE;
        left = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(100, 300);
            end
            left--;
            phase++;
            case (mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: out_stall <= ((phase % 8) < 3);
                default:        out_stall <= ((phase % 16) < 12);
            endcase
        end
    end

    // result checker and handshake activity counter
    always @(posedge clk)
    begin
        table_result_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: status %0d", status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (evicted_key !== want.evicted_key)
                begin
                    $error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
                    error_count++;
                end
                if (level_now !== want.level_now)
                begin
                    $error("level_now: expected %0d, got %0d", want.level_now, level_now);
                    error_count++;
                end
                if (removed_count !== want.removed_count)
                begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed_count, removed_count);
                    error_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $error("no handshake for %0d cycles, %0d results pending",
               quiet_cycles, pending_results.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int k;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        cmd      <= CMD_ACTIVATE;
        node_key <= '0;
        boost    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        for (k = 0; k < POOL_SIZE; k++)
            key_pool[k] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h5555_5555_5555_5555;
        key_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_cases();
        test_churn_small_table();
        test_fill_and_evict();
        test_full_wipe();
        test_harsh_decay();
        test_extreme_settings();
        test_fresh_keys();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("sent %0d words: %0d hits, %0d inserts, %0d evictions, %0d decay ticks",
                 words_sent, hit_count, insert_count, evict_count, tick_count);
        $display("decay ticks dropped %0d entries over %0d register writes",
                 dropped_total, settings_used);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
